// ----- rtl/core/rppr_ik_pkg.sv -----
// Shared types, constants and the arctangent table for the arm inverse kinematics pipeline.
`timescale 1ns / 1ps

package rppr_ik_pkg;

    // Number of CORDIC micro-rotations; the table only covers 32 steps
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_RUN   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    // Working width of the CORDIC vector: a negated -2^31 plus the CORDIC gain fits in 35 bits
    localparam int CORDIC_W = 35;

    // CORDIC gain correction 0.60725293500888 in Q31
    localparam logic [30:0] GAIN_Q31 = 31'd1304065748;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_HEIGHT   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIAL_OFFSET = 1'b1;

    // Half turn as a binary angle
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] target_angle;
    } target_t;

    typedef struct packed {
        logic signed [31:0] base_angle;
        logic signed [31:0] lift_travel;
        logic signed [31:0] reach_travel;
        logic signed [31:0] wrist_angle;
    } joints_t;

    // Transaction state carried along the rotation pipeline
    typedef struct packed {
        logic                       zero;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [31:0]                acc;
        logic signed [31:0]         lift;
        logic [31:0]                tool;
    } cordic_t;

    // Transaction state after gain correction
    typedef struct packed {
        logic [32:0]        radius;
        logic [31:0]        acc;
        logic signed [31:0] lift;
        logic [31:0]        tool;
    } gain_t;

    // atan(2^-step) in binary-angle units
    function automatic logic [31:0] atan_angle(input int unsigned step);
        logic [31:0] a;
        case (step)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            24:      a = 32'd41;
            25:      a = 32'd20;
            26:      a = 32'd10;
            27:      a = 32'd5;
            28:      a = 32'd3;
            29:      a = 32'd1;
            30:      a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/core/rppr_ik_cordic.sv -----
// Unrolled vectoring CORDIC: one registered micro-rotation per stage.
`timescale 1ns / 1ps

module rppr_ik_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 head_valid,
    input  rppr_ik_pkg::cordic_t head,
    output logic                 tail_valid,
    output rppr_ik_pkg::cordic_t tail
);

    localparam int N = rppr_ik_pkg::CORDIC_RUN;

    rppr_ik_pkg::cordic_t stage_in   [N];
    rppr_ik_pkg::cordic_t stage_next [N];
    rppr_ik_pkg::cordic_t data_reg   [N];
    logic [N-1:0]         vin;
    logic [N-1:0]         vld_reg;

    assign stage_in[0] = head;
    assign vin[0]      = head_valid;

    for (genvar i = 0; i < N; i++) begin : g_step

        // Chain each stage to the previous register
        if (i > 0) begin : g_link
            assign stage_in[i] = data_reg[i-1];
            assign vin[i]      = vld_reg[i-1];
        end

        // Rotate towards the x axis, steering by the sign of y
        always_comb
        begin
            logic signed [rppr_ik_pkg::CORDIC_W-1:0] dx;
            logic signed [rppr_ik_pkg::CORDIC_W-1:0] dy;
            dx = $signed(stage_in[i].y) >>> i;
            dy = $signed(stage_in[i].x) >>> i;
            stage_next[i] = stage_in[i];
            if (!stage_in[i].y[rppr_ik_pkg::CORDIC_W-1])
            begin
                stage_next[i].x   = stage_in[i].x + dx;
                stage_next[i].y   = stage_in[i].y - dy;
                stage_next[i].acc = stage_in[i].acc + rppr_ik_pkg::atan_angle(i);
            end
            else
            begin
                stage_next[i].x   = stage_in[i].x - dx;
                stage_next[i].y   = stage_in[i].y + dy;
                stage_next[i].acc = stage_in[i].acc - rppr_ik_pkg::atan_angle(i);
            end
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i] <= vin[i];
            end
        end

        // Advance the payload
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                data_reg[i] <= stage_next[i];
            end
        end
    end

    assign tail       = data_reg[N-1];
    assign tail_valid = vld_reg[N-1];

endmodule

// ----- rtl/core/rppr_ik_gain.sv -----
// Gain correction: split 34x31 multiply in two stages, the last rounding to radius.
`timescale 1ns / 1ps

module rppr_ik_gain (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 head_valid,
    input  rppr_ik_pkg::cordic_t head,
    output logic                 tail_valid,
    output rppr_ik_pkg::gain_t   tail
);

    logic [33:0]        mag;
    logic [31:0]        acc_masked;
    logic [47:0]        lo_reg;
    logic [47:0]        hi_reg;
    logic [31:0]        acc_reg;
    logic signed [31:0] lift_reg;
    logic [31:0]        tool_reg;
    logic               prod_valid_reg;
    logic [64:0]        sum;
    rppr_ik_pkg::gain_t out_reg;
    logic               out_valid_reg;

    // Clamp a negative magnitude to zero and drop the origin case
    always_comb
    begin
        if (head.zero || head.x[rppr_ik_pkg::CORDIC_W-1])
        begin
            mag = '0;
        end
        else
        begin
            mag = head.x[33:0];
        end
        acc_masked = head.zero ? 32'd0 : head.acc;
    end

    // Partial products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg   <= 48'(mag[16:0])  * 48'(rppr_ik_pkg::GAIN_Q31);
            hi_reg   <= 48'(mag[33:17]) * 48'(rppr_ik_pkg::GAIN_Q31);
            acc_reg  <= acc_masked;
            lift_reg <= head.lift;
            tool_reg <= head.tool;
        end
    end

    // Combine partial products and round from Q31
    assign sum = {hi_reg, 17'd0} + {17'd0, lo_reg} + (65'd1 << 30);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.radius <= sum[63:31];
            out_reg.acc    <= acc_reg;
            out_reg.lift   <= lift_reg;
            out_reg.tool   <= tool_reg;
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            prod_valid_reg <= head_valid;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    assign tail       = out_reg;
    assign tail_valid = out_valid_reg;

endmodule

// ----- rtl/core/rppr_arm_inverse_kinematics.sv -----
// Top level: target entry stage, CORDIC pipeline, gain correction and joint output stage.
// Path: a target is registered through the entry register, the CORDIC stages, the gain stages and the output register.
// Throughput: one target per cycle; every stage moves together whenever the output register
// is empty or its result is being taken, and a held result holds the whole pipeline.
// Reset: rst_n clears all valid bits and both offset registers to zero; no clearing pass.
`timescale 1ns / 1ps

module rppr_arm_inverse_kinematics (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   target_valid,
    output logic                                   target_stall,
    input  rppr_ik_pkg::target_t                   target,
    output logic                                   joint_valid,
    input  logic                                   joint_stall,
    output rppr_ik_pkg::joints_t                   joint,
    input  logic                                   cfg_write_en,
    input  logic [rppr_ik_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                            cfg_data
);

    logic signed [31:0]   base_height_reg;
    logic signed [31:0]   radial_offset_reg;
    logic                 adv;
    rppr_ik_pkg::cordic_t entry_next;
    rppr_ik_pkg::cordic_t entry_reg;
    logic                 entry_valid_reg;
    logic                 rot_valid;
    rppr_ik_pkg::cordic_t rot;
    logic                 gain_valid;
    rppr_ik_pkg::gain_t   gain;
    rppr_ik_pkg::joints_t out_next;
    rppr_ik_pkg::joints_t out_reg;
    logic                 out_valid_reg;

    // Clamp a 35-bit signed difference to the 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -35'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_height_reg   <= '0;
            radial_offset_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                rppr_ik_pkg::CFG_BASE_HEIGHT:   base_height_reg   <= cfg_data;
                rppr_ik_pkg::CFG_RADIAL_OFFSET: radial_offset_reg <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // Move the whole pipeline unless a finished result is held
    assign adv          = !out_valid_reg || !joint_stall;
    assign target_stall = !adv;

    // Entry: swap to (y, x), fold the left half-plane and compute the lift
    always_comb
    begin
        logic signed [rppr_ik_pkg::CORDIC_W-1:0] cx;
        logic signed [rppr_ik_pkg::CORDIC_W-1:0] cy;
        logic signed [32:0]                      lift_diff;
        cx = rppr_ik_pkg::CORDIC_W'(target.target_y);
        cy = rppr_ik_pkg::CORDIC_W'(target.target_x);
        lift_diff = 33'(target.target_z) - 33'(base_height_reg);
        entry_next.zero = (target.target_x == 32'sd0) && (target.target_y == 32'sd0);
        entry_next.lift = sat32(35'(lift_diff));
        entry_next.tool = target.target_angle;
        if (cx[rppr_ik_pkg::CORDIC_W-1])
        begin
            entry_next.x   = -cx;
            entry_next.y   = -cy;
            entry_next.acc = rppr_ik_pkg::HALF_TURN;
        end
        else
        begin
            entry_next.x   = cx;
            entry_next.y   = cy;
            entry_next.acc = 32'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            entry_reg <= entry_next;
        end
    end

    rppr_ik_cordic u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .head_valid (entry_valid_reg),
        .head       (entry_reg),
        .tail_valid (rot_valid),
        .tail       (rot)
    );

    rppr_ik_gain u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .head_valid (rot_valid),
        .head       (rot),
        .tail_valid (gain_valid),
        .tail       (gain)
    );

    // Output: reach saturation and wrist wrap
    always_comb
    begin
        logic signed [34:0] reach_diff;
        reach_diff = $signed({2'b00, gain.radius}) - 35'(radial_offset_reg);
        out_next.base_angle   = gain.acc;
        out_next.lift_travel  = gain.lift;
        out_next.reach_travel = sat32(reach_diff);
        out_next.wrist_angle  = gain.tool - gain.acc;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    // Advance the valid bits at either end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            entry_valid_reg <= target_valid;
            out_valid_reg   <= gain_valid;
        end
    end

    assign joint       = out_reg;
    assign joint_valid = out_valid_reg;

    // A corrected transaction that advances always lands in the output register
    a_gain_lands: assert property (@(posedge clk) disable iff (!rst_n)
        adv && gain_valid |=> out_valid_reg)
        else $error("corrected transaction lost before output");

    // A held result is never dropped or altered while the pipeline waits
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && joint_stall |=> out_valid_reg && $stable(out_reg))
        else $error("held result dropped");

    // Radius is never negative, so reach can never reach the lower clamp
    a_reach_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.reach_travel != 32'sh8000_0000)
        else $error("reach travel below possible range");

endmodule

// ----- bench/rppr_ik_checker.sv -----
// Checker for the arm inverse kinematics block: joint prediction, scoreboard and comparison.
`timescale 1ns / 1ps

module rppr_ik_checker
    import rppr_ik_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   target_valid,
    input  logic                   target_stall,
    input  target_t                target,
    input  logic                   joint_valid,
    input  logic                   joint_stall,
    input  joints_t                joint,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    output int                     failures,
    output int                     outstanding,
    output int                     checked
);

    // Micro-rotations actually run; the angle table stops at 32 entries
    localparam int ROTATIONS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    // Gain correction 0.60725293500888 in Q31
    localparam longint GAIN_CORRECTION = 64'sd1304065748;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    // atan(2^-i) in binary-angle units
    logic [31:0] arctan_units [32];

    initial
    begin
        arctan_units = '{
            32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
            32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
            32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
            32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
            32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
        };
    end

    // Offsets as last written through the configuration port
    logic signed [31:0] height_q;
    logic signed [31:0] offset_q;

    // Joint values predicted for targets still in flight, oldest first
    joints_t pending_joints [$];

    // Clamp a wide difference into signed 32-bit range
    function automatic logic [31:0] clamp_q(input longint v);
        if (v > Q_MAX)
            return Q_MAX[31:0];
        if (v < Q_MIN)
            return Q_MIN[31:0];
        return v[31:0];
    endfunction

    // Solve the four joints for one target with the current offsets
    function automatic joints_t solve_joints(input target_t t);
        longint      vx;
        longint      vy;
        longint      dx;
        longint      dy;
        longint      radius;
        logic [31:0] heading;
        joints_t     j;
        vx      = longint'(t.target_y);
        vy      = longint'(t.target_x);
        heading = '0;
        radius  = 0;
        if (vx != 0 || vy != 0)
        begin
            // Fold the left half-plane onto the right and start half a turn round
            if (vx < 0)
            begin
                vx      = -vx;
                vy      = -vy;
                heading = HALF_TURN;
            end
            // Rotate the vector onto the x axis, summing the angle turned
            for (int i = 0; i < ROTATIONS; i++)
            begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (vy >= 0)
                begin
                    vx      = vx + dx;
                    vy      = vy - dy;
                    heading = heading + arctan_units[i];
                end
                else
                begin
                    vx      = vx - dx;
                    vy      = vy + dy;
                    heading = heading - arctan_units[i];
                end
            end
            if (vx < 0)
                vx = 0;
            radius = (vx * GAIN_CORRECTION + (64'sd1 <<< 30)) >>> 31;
        end
        j.base_angle   = heading;
        j.lift_travel  = clamp_q(longint'(t.target_z) - longint'(height_q));
        j.reach_travel = clamp_q(radius - longint'(offset_q));
        j.wrist_angle  = t.target_angle - heading;
        return j;
    endfunction

    // Compare one field and count a mismatch
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
            failures++;
        end
    endtask

    // Track offsets, queue predictions on target transactions, match joint transactions
    always @(posedge clk or negedge rst_n)
    begin
        joints_t want;
        if (!rst_n)
        begin
            height_q    <= '0;
            offset_q    <= '0;
            pending_joints.delete();
            outstanding <= 0;
            failures    = 0;
            checked     = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_BASE_HEIGHT:   height_q <= cfg_data;
                    CFG_RADIAL_OFFSET: offset_q <= cfg_data;
                    default: ;
                endcase
            end
            if (target_valid && !target_stall)
                pending_joints.push_back(solve_joints(target));
            if (joint_valid && !joint_stall)
            begin
                if (pending_joints.size() == 0)
                begin
                    $error("joint transaction with no target outstanding");
                    failures++;
                end
                else
                begin
                    want = pending_joints.pop_front();
                    check_field("base_angle", want.base_angle, joint.base_angle);
                    check_field("lift_travel", want.lift_travel, joint.lift_travel);
                    check_field("reach_travel", want.reach_travel, joint.reach_travel);
                    check_field("wrist_angle", want.wrist_angle, joint.wrist_angle);
                    checked++;
                end
            end
            outstanding <= pending_joints.size();
        end
    end

endmodule

// ----- bench/rppr_arm_inverse_kinematics_tb.sv -----
// Testbench top for the arm inverse kinematics block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rppr_arm_inverse_kinematics_tb;
    import rppr_ik_pkg::*;

    localparam int LATENCY      = CORDIC_STEPS + 4;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 136;
    localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] NEG_MAX = 32'sh8000_0000;
    localparam logic signed [31:0] ONE_Q   = 32'sh0001_0000;

    logic                   clk;
    logic                   rst_n;
    logic                   target_valid;
    logic                   target_stall;
    target_t                target;
    logic                   joint_valid;
    logic                   joint_stall;
    joints_t                joint;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;

    int failures;
    int outstanding;
    int checked;
    int idle_pct;
    int directed_sent;
    int random_sent;

    rppr_arm_inverse_kinematics uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .target_valid (target_valid),
        .target_stall (target_stall),
        .target       (target),
        .joint_valid  (joint_valid),
        .joint_stall  (joint_stall),
        .joint        (joint),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rppr_ik_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .target_valid (target_valid),
        .target_stall (target_stall),
        .target       (target),
        .joint_valid  (joint_valid),
        .joint_stall  (joint_stall),
        .joint        (joint),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .outstanding  (outstanding),
        .checked      (checked)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    // Hold off joint results in random bursts while idling is enabled
    initial
    begin
        joint_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_pct > 0 && $urandom_range(99) < idle_pct)
            begin
                joint_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                joint_stall <= 1'b0;
            end
        end
    end

    function automatic target_t make_target(input logic signed [31:0] x,
                                            input logic signed [31:0] y,
                                            input logic signed [31:0] z,
                                            input logic signed [31:0] a);
        target_t t;
        t.target_x     = x;
        t.target_y     = y;
        t.target_z     = z;
        t.target_angle = a;
        return t;
    endfunction

    // Position of working size: a few thousand units down to fractions
    function automatic logic signed [31:0] near_value();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(4, 16);
    endfunction

    function automatic logic signed [31:0] extreme_value();
        case ($urandom_range(5))
            0:       return POS_MAX;
            1:       return NEG_MAX;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4:       return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly working-range targets, then full-range, on-axis and extreme ones
    function automatic target_t random_target();
        target_t     t;
        int unsigned pick;
        pick = $urandom_range(9);
        t    = make_target($urandom, $urandom, $urandom, $urandom);
        if (pick < 6)
        begin
            t.target_x = near_value();
            t.target_y = near_value();
            t.target_z = near_value();
        end
        else if (pick == 8)
        begin
            case ($urandom_range(2))
                0:       t.target_x = '0;
                1:       t.target_y = '0;
                default:
                begin
                    t.target_x = '0;
                    t.target_y = '0;
                end
            endcase
        end
        else if (pick == 9)
        begin
            t.target_x     = extreme_value();
            t.target_y     = extreme_value();
            t.target_z     = extreme_value();
            t.target_angle = extreme_value();
        end
        return t;
    endfunction

    // Offer one target after an optional gap and hold it until taken
    task automatic send_target(input target_t t);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            target_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        target       <= t;
        target_valid <= 1'b1;
        @(posedge clk);
        while (target_stall)
            @(posedge clk);
    endtask

    // Drop valid and let every outstanding result drain out
    task automatic drain();
        target_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Write both offsets on consecutive edges
    task automatic set_offsets(input logic [31:0] height, input logic [31:0] offset);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_BASE_HEIGHT;
        cfg_data     <= height;
        @(posedge clk);
        cfg_index    <= CFG_RADIAL_OFFSET;
        cfg_data     <= offset;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic send_directed(input target_t t);
        send_target(t);
        directed_sent++;
    endtask

    // Stimulus and verdict
    initial
    begin
        logic signed [31:0] heights [PHASES];
        logic signed [31:0] offsets [PHASES];
        int                 idle_plan [PHASES];

        rst_n         = 1'b0;
        target_valid  = 1'b0;
        target        = '0;
        cfg_write_en  = 1'b0;
        cfg_index     = CFG_BASE_HEIGHT;
        cfg_data      = '0;
        idle_pct      = 0;
        directed_sent = 0;
        random_sent   = 0;

        heights   = '{32'sd0, POS_MAX, NEG_MAX, near_value(), $urandom};
        offsets   = '{32'sd0, NEG_MAX, POS_MAX, near_value(), $urandom};
        idle_plan = '{30, 60, 0, 25, 0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: origin, axes, quadrants, extremes and wrist wrap at reset offsets
        idle_pct = 20;
        send_directed(make_target(32'sd0, 32'sd0, 32'sd0, 32'sd0));
        send_directed(make_target(32'sd0, 32'sd0, POS_MAX, NEG_MAX));
        send_directed(make_target(32'sd0, 32'sd0, NEG_MAX, POS_MAX));
        send_directed(make_target(ONE_Q, 32'sd0, ONE_Q, 32'sd0));
        send_directed(make_target(-ONE_Q, 32'sd0, -ONE_Q, 32'sd0));
        send_directed(make_target(32'sd0, ONE_Q, 32'sd0, ONE_Q));
        send_directed(make_target(32'sd0, -ONE_Q, 32'sd0, ONE_Q));
        send_directed(make_target(ONE_Q, -ONE_Q, 32'sd5, 32'sd0));
        send_directed(make_target(-ONE_Q, -ONE_Q, -32'sd5, 32'sd0));
        send_directed(make_target(-ONE_Q, ONE_Q, 32'sd7, POS_MAX));
        send_directed(make_target(POS_MAX, POS_MAX, POS_MAX, POS_MAX));
        send_directed(make_target(NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX));
        send_directed(make_target(NEG_MAX, 32'sd0, 32'sd0, 32'sd0));
        send_directed(make_target(32'sd0, NEG_MAX, 32'sd0, 32'sd0));
        send_directed(make_target(POS_MAX, NEG_MAX, 32'sd0, NEG_MAX));
        send_directed(make_target(NEG_MAX, POS_MAX, 32'sd0, POS_MAX));
        send_directed(make_target(32'sd1, 32'sd0, 32'sd0, 32'sd0));
        send_directed(make_target(32'sd0, -32'sd1, 32'sd0, 32'sd0));
        send_directed(make_target(-32'sd1, -32'sd1, -32'sd1, -32'sd1));
        send_directed(make_target(ONE_Q, ONE_Q, 32'sd0, NEG_MAX));
        send_directed(make_target(-ONE_Q, -ONE_Q, 32'sd0, POS_MAX));

        // Random phases, each under its own offsets and idling rate
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            set_offsets(heights[p], offsets[p]);
            idle_pct = idle_plan[p];
            repeat (PHASE_ITEMS)
            begin
                send_target(random_target());
                random_sent++;
            end
        end

        drain();
        $display("Checked %0d joint transactions: %0d directed and %0d random targets",
                 checked, directed_sent, random_sent);
        $display("over %0d offset settings, extremes included, with random idling on both sides.",
                 PHASES);
        if (failures == 0)
            $display("rppr_arm_inverse_kinematics test passed");
        else
            $display("rppr_arm_inverse_kinematics test failed");
        $finish;
    end

    // Give up if the run hangs
    initial
    begin
        #2_000_000;
        $display("rppr_arm_inverse_kinematics test failed");
        $finish;
    end

endmodule
